// ===== hdl/gdtp_pkg.sv =====
`timescale 1ns / 1ps
package gdtp_pkg;

  localparam int SRC_WIDTH_DEF      = 320;
  localparam int SRC_HEIGHT_DEF     = 240;
  localparam int DST_WIDTH_DEF      = 128;
  localparam int DST_HEIGHT_DEF     = 96;
  localparam int ROW_BYTE_COUNT_DEF = 16;
  localparam int PANEL_ROWS_DEF     = 296;

  localparam int THRESHOLD_W  = 8;
  localparam int TOP_ROW_W    = 9;
  localparam int ADDR_W       = 13;
  // top_row (9b) plus a destination row of up to 8191 (13b)
  localparam int PANEL_ROW_W  = 14;

  localparam int CFG_INDEX_W  = 1;
  localparam int CFG_DATA_W   = 9;

  localparam logic [CFG_INDEX_W-1:0] CFG_THRESHOLD = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_TOP_ROW   = 1'd1;

  localparam logic [THRESHOLD_W-1:0] THRESHOLD_RESET = 8'd128;
  localparam logic [TOP_ROW_W-1:0]   TOP_ROW_RESET   = 9'd100;

  typedef struct packed {
    logic [7:0] pixel;
    logic       frame_start;
  } in_t;

  typedef struct packed {
    logic [7:0]        packed_byte;
    logic [ADDR_W-1:0] byte_address;
    logic              frame_last;
  } out_t;

  typedef struct packed {
    logic [THRESHOLD_W-1:0] threshold;
    logic [TOP_ROW_W-1:0]   top_row;
  } cfg_t;

endpackage

// ===== hdl/gdtp_core.sv =====
`timescale 1ns / 1ps
module gdtp_core #(
  parameter int SRC_WIDTH      = 320,
  parameter int SRC_HEIGHT     = 240,
  parameter int DST_WIDTH      = 128,
  parameter int DST_HEIGHT     = 96,
  parameter int ROW_BYTE_COUNT = 16,
  parameter int PANEL_ROWS     = 296
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           accept,
  input  gdtp_pkg::in_t  item,
  input  gdtp_pkg::cfg_t cfg,
  output logic           result_valid,
  output gdtp_pkg::out_t result
);
  import gdtp_pkg::*;

  localparam int SCOL_W = $clog2(SRC_WIDTH + 1);
  localparam int SROW_W = $clog2(SRC_HEIGHT + 1);
  localparam int DCOL_W = $clog2(DST_WIDTH + 1);
  localparam int DROW_W = $clog2(DST_HEIGHT + 1);
  localparam int CREM_W = $clog2(DST_WIDTH + 1) + 1;
  localparam int RREM_W = $clog2(DST_HEIGHT + 1) + 1;

  // floor(k*S/D) is tracked as quotient plus remainder, stepped by S/D and S%D
  localparam int COL_Q = SRC_WIDTH / DST_WIDTH;
  localparam int COL_R = SRC_WIDTH % DST_WIDTH;
  localparam int ROW_Q = SRC_HEIGHT / DST_HEIGHT;
  localparam int ROW_R = SRC_HEIGHT % DST_HEIGHT;

  logic [SCOL_W-1:0] src_col, src_col_next, c_src_col, src_col_inc;
  logic [SROW_W-1:0] src_row, src_row_next, c_src_row, src_row_inc;
  logic [DCOL_W-1:0] dst_col, dst_col_next, c_dst_col, dst_col_inc;
  logic [DROW_W-1:0] dst_row, dst_row_next, c_dst_row, dst_row_inc;
  logic [SCOL_W-1:0] next_src_col, next_src_col_next, c_next_src_col;
  logic [SROW_W-1:0] next_src_row, next_src_row_next, c_next_src_row;
  logic [CREM_W-1:0] col_rem, col_rem_next, c_col_rem, col_rem_sum;
  logic [RREM_W-1:0] row_rem, row_rem_next, c_row_rem, row_rem_sum;
  logic              row_kept, row_kept_next, c_row_kept;
  logic [7:0]        bit_shift, bit_shift_next, c_bit_shift, shift_new, padded;
  logic [2:0]        bit_count, bit_count_next, c_bit_count;
  logic [3:0]        count_new, pad_amt;
  logic              pix_bit, emit;
  logic [DCOL_W-1:0] byte_col;
  logic [PANEL_ROW_W-1:0] panel_row;

  always_comb begin
    // frame_start restarts everything before the pixel is used
    c_src_col      = item.frame_start ? '0 : src_col;
    c_src_row      = item.frame_start ? '0 : src_row;
    c_dst_col      = item.frame_start ? '0 : dst_col;
    c_dst_row      = item.frame_start ? '0 : dst_row;
    c_next_src_col = item.frame_start ? '0 : next_src_col;
    c_next_src_row = item.frame_start ? '0 : next_src_row;
    c_col_rem      = item.frame_start ? '0 : col_rem;
    c_row_rem      = item.frame_start ? '0 : row_rem;
    c_row_kept     = item.frame_start ? 1'b1 : row_kept;
    c_bit_shift    = item.frame_start ? '0 : bit_shift;
    c_bit_count    = item.frame_start ? '0 : bit_count;

    src_col_next      = c_src_col;
    src_row_next      = c_src_row;
    dst_col_next      = c_dst_col;
    dst_row_next      = c_dst_row;
    next_src_col_next = c_next_src_col;
    next_src_row_next = c_next_src_row;
    col_rem_next      = c_col_rem;
    row_rem_next      = c_row_rem;
    row_kept_next     = c_row_kept;
    bit_shift_next    = c_bit_shift;
    bit_count_next    = c_bit_count;

    pix_bit     = (item.pixel >= cfg.threshold);
    shift_new   = {c_bit_shift[6:0], pix_bit};
    count_new   = {1'b0, c_bit_count} + 4'd1;
    pad_amt     = 4'd8 - count_new;
    padded      = (shift_new << pad_amt) | (8'hFF >> count_new);
    dst_col_inc = c_dst_col + DCOL_W'(1);
    col_rem_sum = c_col_rem + CREM_W'(COL_R);
    src_col_inc = c_src_col + SCOL_W'(1);
    src_row_inc = c_src_row + SROW_W'(1);
    dst_row_inc = c_dst_row + DROW_W'(1);
    row_rem_sum = c_row_rem + RREM_W'(ROW_R);
    byte_col    = c_dst_col >> 3;
    panel_row   = PANEL_ROW_W'(cfg.top_row) + PANEL_ROW_W'(c_dst_row);
    emit        = 1'b0;

    result_valid        = 1'b0;
    result.packed_byte  = (count_new == 4'd8) ? shift_new : padded;
    result.byte_address = ADDR_W'(panel_row[ADDR_W-1:0] * ADDR_W'(ROW_BYTE_COUNT))
                          + ADDR_W'(byte_col);
    result.frame_last   = (dst_col_inc == DCOL_W'(DST_WIDTH)) &&
                          ((DROW_W + 1)'(c_dst_row) + (DROW_W + 1)'(1) ==
                           (DROW_W + 1)'(DST_HEIGHT));

    if (c_src_row < SROW_W'(SRC_HEIGHT)) begin
      if (c_row_kept && c_dst_col < DCOL_W'(DST_WIDTH) && c_src_col >= c_next_src_col) begin
        dst_col_next   = dst_col_inc;
        bit_shift_next = shift_new;
        bit_count_next = count_new[2:0];
        if (col_rem_sum >= CREM_W'(DST_WIDTH)) begin
          col_rem_next      = col_rem_sum - CREM_W'(DST_WIDTH);
          next_src_col_next = c_next_src_col + SCOL_W'(COL_Q) + SCOL_W'(1);
        end else begin
          col_rem_next      = col_rem_sum;
          next_src_col_next = c_next_src_col + SCOL_W'(COL_Q);
        end
        emit = (count_new == 4'd8) || (dst_col_inc == DCOL_W'(DST_WIDTH));
        if (emit) begin
          bit_shift_next = '0;
          bit_count_next = '0;
          // bytes off the bottom or right of the panel are dropped
          if (panel_row < PANEL_ROW_W'(PANEL_ROWS) &&
              14'(byte_col) < 14'(ROW_BYTE_COUNT)) begin
            result_valid = accept;
          end
        end
      end

      if (src_col_inc >= SCOL_W'(SRC_WIDTH)) begin
        src_col_next      = '0;
        src_row_next      = src_row_inc;
        dst_col_next      = '0;
        next_src_col_next = '0;
        col_rem_next      = '0;
        bit_shift_next    = '0;
        bit_count_next    = '0;
        if (c_row_kept) begin
          dst_row_next = dst_row_inc;
          if (row_rem_sum >= RREM_W'(DST_HEIGHT)) begin
            row_rem_next      = row_rem_sum - RREM_W'(DST_HEIGHT);
            next_src_row_next = c_next_src_row + SROW_W'(ROW_Q) + SROW_W'(1);
          end else begin
            row_rem_next      = row_rem_sum;
            next_src_row_next = c_next_src_row + SROW_W'(ROW_Q);
          end
        end
        row_kept_next = (dst_row_next < DROW_W'(DST_HEIGHT)) &&
                        (src_row_inc >= next_src_row_next);
      end else begin
        src_col_next = src_col_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      src_col      <= '0;
      src_row      <= '0;
      dst_col      <= '0;
      dst_row      <= '0;
      next_src_col <= '0;
      next_src_row <= '0;
      col_rem      <= '0;
      row_rem      <= '0;
      row_kept     <= 1'b1;
      bit_shift    <= '0;
      bit_count    <= '0;
    end else if (accept) begin
      src_col      <= src_col_next;
      src_row      <= src_row_next;
      dst_col      <= dst_col_next;
      dst_row      <= dst_row_next;
      next_src_col <= next_src_col_next;
      next_src_row <= next_src_row_next;
      col_rem      <= col_rem_next;
      row_rem      <= row_rem_next;
      row_kept     <= row_kept_next;
      bit_shift    <= bit_shift_next;
      bit_count    <= bit_count_next;
    end
  end

endmodule

// ===== hdl/gdtp_skid.sv =====
`timescale 1ns / 1ps
module gdtp_skid (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  gdtp_pkg::out_t push_data,
  output logic           full,
  output logic           valid,
  input  logic           stall,
  output gdtp_pkg::out_t data
);
  import gdtp_pkg::*;

  logic skid_valid;
  out_t skid_data;
  logic pop;

  assign pop   = valid && !stall;
  assign full  = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid      <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (!valid || pop) begin
        valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (pop) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        data <= skid_data;
      end
    end else if (push) begin
      if (!valid || pop) begin
        data <= push_data;
      end else begin
        skid_data <= push_data;
      end
    end
  end

endmodule

// ===== hdl/gray_downscale_threshold_pack_top.sv =====
`timescale 1ns / 1ps
// A finished byte is written into the output buffer by the transfer that takes the pixel
// completing it. One pixel per cycle is taken while pixel_stall is low; the counter and
// threshold update is combinational logic, and a two-entry output buffer only
// stalls pixels when it holds two untaken bytes.
// Reset (rst, synchronous): counters cleared, threshold 128, top row 100, output empty.
module gray_downscale_threshold_pack_top #(
  parameter int SRC_WIDTH      = gdtp_pkg::SRC_WIDTH_DEF,
  parameter int SRC_HEIGHT     = gdtp_pkg::SRC_HEIGHT_DEF,
  parameter int DST_WIDTH      = gdtp_pkg::DST_WIDTH_DEF,
  parameter int DST_HEIGHT     = gdtp_pkg::DST_HEIGHT_DEF,
  parameter int ROW_BYTE_COUNT = gdtp_pkg::ROW_BYTE_COUNT_DEF,
  parameter int PANEL_ROWS     = gdtp_pkg::PANEL_ROWS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 pixel_valid,
  output logic                                 pixel_stall,
  input  gdtp_pkg::in_t                        pixel_data,
  output logic                                 byte_valid,
  input  logic                                 byte_stall,
  output gdtp_pkg::out_t                       byte_data,
  input  logic                                 cfg_we,
  input  logic [gdtp_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [gdtp_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import gdtp_pkg::*;

  cfg_t cfg;
  logic accept;
  logic result_valid;
  out_t result;
  logic buf_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.threshold <= THRESHOLD_RESET;
      cfg.top_row   <= TOP_ROW_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_THRESHOLD: cfg.threshold <= cfg_data[THRESHOLD_W-1:0];
        CFG_TOP_ROW:   cfg.top_row   <= cfg_data[TOP_ROW_W-1:0];
        default: ;
      endcase
    end
  end

  assign pixel_stall = buf_full;
  assign accept      = pixel_valid && !buf_full;

  gdtp_core #(
    .SRC_WIDTH      (SRC_WIDTH),
    .SRC_HEIGHT     (SRC_HEIGHT),
    .DST_WIDTH      (DST_WIDTH),
    .DST_HEIGHT     (DST_HEIGHT),
    .ROW_BYTE_COUNT (ROW_BYTE_COUNT),
    .PANEL_ROWS     (PANEL_ROWS)
  ) u_core (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .item         (pixel_data),
    .cfg          (cfg),
    .result_valid (result_valid),
    .result       (result)
  );

  gdtp_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .push      (result_valid),
    .push_data (result),
    .full      (buf_full),
    .valid     (byte_valid),
    .stall     (byte_stall),
    .data      (byte_data)
  );

endmodule
